// ----- rtl/rf_power_detector_linearizer_top_macros.svh -----
// Assertion macros shared by the checker of the power detector linearizer.
`ifndef RF_POWER_DETECTOR_LINEARIZER_TOP_MACROS_SVH
`define RF_POWER_DETECTOR_LINEARIZER_TOP_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define RFPDL_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define RFPDL_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- rtl/rfpdl_pkg.sv -----
// Shared types, constants and rounding helper of the power detector linearizer.
package rfpdl_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int MAX_AVERAGE     = 256;
  localparam int BAR_MAX         = 128;
  localparam int CNT_W           = 9;
  localparam int SUM_W           = 21;
  localparam int RAW_W           = 20;
  localparam int CORR_W          = 23;
  localparam int V_W             = 22;
  localparam int V2_W            = 24;
  localparam int V3_W            = 26;
  localparam int MUL_W           = 33;
  localparam int PROD_W          = 66;
  localparam int ACC_W           = 61;
  localparam int FRAC_W          = 16;
  localparam int EXP_W           = 5;
  localparam int LOG_W           = 22;
  localparam int TENTHS_W        = 11;
  localparam int BAR_W           = 8;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;
  localparam int LOG_K           = 1972830;
  localparam int LOG_BIAS        = 24 * 65536;
  localparam int TENTHS_BELOW    = -990;
  localparam int TENTHS_MAX      = 600;
  localparam int TENTHS_OFFSET   = 300;

  typedef enum logic [2:0] {
    REG_SAMPLE_COUNT,
    REG_OFFSET_ADJUST,
    REG_CAL_FACTOR,
    REG_COEF_CONST,
    REG_COEF_LINEAR,
    REG_COEF_SQUARE,
    REG_COEF_CUBE,
    REG_POWER_MIN
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACC,
    OP_CORR,
    OP_MUL_V,
    OP_RND_V,
    OP_MUL_V2,
    OP_RND_V2,
    OP_MUL_V3,
    OP_RND_V3,
    OP_MUL_C1,
    OP_MUL_C2,
    OP_MUL_C3,
    OP_ADD,
    OP_PWR,
    OP_NORM_LD,
    OP_NORM,
    OP_SQ_MUL,
    OP_SQ_UPD,
    OP_LOG_MUL,
    OP_LOG_RND,
    OP_LOAD
  } op_t;

  typedef struct packed {
    logic last;
    logic skip_log;
    logic norm_done;
    logic sq_done;
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0]  sample_count;
    logic signed [11:0] offset_adjust;
    logic [31:0]        cal_factor;
    logic signed [31:0] coef_const;
    logic signed [31:0] coef_linear;
    logic signed [31:0] coef_square;
    logic signed [31:0] coef_cube;
    logic [30:0]        power_min;
  } cfg_t;

  // Shift right by n, rounding to nearest with ties away from zero.
  function automatic logic signed [PROD_W-1:0] rshr(input logic signed [PROD_W-1:0] v,
                                                    input int unsigned n);
    logic [PROD_W-1:0] mag;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    mag = (mag + (PROD_W'(1) << (n - 1))) >> n;
    return v[PROD_W-1] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ----- rtl/rfpdl_regs.sv -----
// APB configuration register file of the power detector linearizer.
module rfpdl_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rfpdl_pkg::ADDR_W-1:0] paddr,
  input  logic [rfpdl_pkg::DATA_W-1:0] pwdata,
  output logic [rfpdl_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output rfpdl_pkg::cfg_t             cfg
);
  import rfpdl_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count  <= CNT_W'(4);
      cfg_r.offset_adjust <= '0;
      cfg_r.cal_factor    <= 32'd67109;
      cfg_r.coef_const    <= -32'sd670;
      cfg_r.coef_linear   <= 32'sd4060326;
      cfg_r.coef_square   <= 32'sd568757568;
      cfg_r.coef_cube     <= '0;
      cfg_r.power_min     <= 31'd16777;
    end else if (wr_en) begin
      unique case (idx)
        REG_SAMPLE_COUNT:  cfg_r.sample_count  <= pwdata[CNT_W-1:0];
        REG_OFFSET_ADJUST: cfg_r.offset_adjust <= $signed(pwdata[11:0]);
        REG_CAL_FACTOR:    cfg_r.cal_factor    <= pwdata;
        REG_COEF_CONST:    cfg_r.coef_const    <= $signed(pwdata);
        REG_COEF_LINEAR:   cfg_r.coef_linear   <= $signed(pwdata);
        REG_COEF_SQUARE:   cfg_r.coef_square   <= $signed(pwdata);
        REG_COEF_CUBE:     cfg_r.coef_cube     <= $signed(pwdata);
        REG_POWER_MIN:     cfg_r.power_min     <= pwdata[30:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SAMPLE_COUNT:  prdata = DATA_W'(cfg_r.sample_count);
      REG_OFFSET_ADJUST: prdata = DATA_W'(cfg_r.offset_adjust);
      REG_CAL_FACTOR:    prdata = cfg_r.cal_factor;
      REG_COEF_CONST:    prdata = cfg_r.coef_const;
      REG_COEF_LINEAR:   prdata = cfg_r.coef_linear;
      REG_COEF_SQUARE:   prdata = cfg_r.coef_square;
      REG_COEF_CUBE:     prdata = cfg_r.coef_cube;
      REG_POWER_MIN:     prdata = DATA_W'(cfg_r.power_min);
    endcase
  end

endmodule

// ----- rtl/rfpdl_datapath.sv -----
// Datapath: sample accumulator, shared multiplier, polynomial and log2 registers.
module rfpdl_datapath #(
  parameter int SAMPLE_BITS = rfpdl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rfpdl_pkg::op_t                      op,
  input  rfpdl_pkg::cfg_t                     cfg,
  input  logic [SAMPLE_BITS-1:0]              in_sample,
  output rfpdl_pkg::status_t                  status,
  output logic [rfpdl_pkg::RAW_W-1:0]         raw_sum,
  output logic signed [rfpdl_pkg::V_W-1:0]    detector_volts,
  output logic signed [31:0]                  power_watts,
  output logic                                below_min,
  output logic signed [rfpdl_pkg::TENTHS_W-1:0] dbm_tenths,
  output logic [rfpdl_pkg::BAR_W-1:0]         bar_width
);
  import rfpdl_pkg::*;

  localparam int K_W = $clog2(FRAC_W);
  localparam logic signed [PROD_W-1:0] V_MAX   = PROD_W'((1 << (V_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] V_MIN   = -PROD_W'(1 << (V_W - 1));
  localparam logic signed [PROD_W-1:0] P_MAX   = PROD_W'(32'sh7FFF_FFFF);
  localparam logic signed [PROD_W-1:0] P_MIN   = -PROD_W'(64'sh8000_0000);
  localparam logic signed [PROD_W-1:0] T_MAX   = PROD_W'(TENTHS_MAX);
  localparam logic signed [PROD_W-1:0] T_MIN   = PROD_W'(TENTHS_BELOW);

  // accumulation state
  logic [SUM_W-1:0] run_r;
  logic [CNT_W-1:0] seen_r;
  // measurement registers
  logic [SUM_W-1:0]           sum_r;
  logic signed [CORR_W-1:0]   corr_r;
  logic signed [V_W-1:0]      v_r;
  logic signed [V2_W-1:0]     v2_r;
  logic signed [V3_W-1:0]     v3_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [31:0]         pwr_r;
  logic                       below_r;
  logic [30:0]                m_r;
  logic [EXP_W-1:0]           e_r;
  logic [FRAC_W-1:0]          frac_r;
  logic [K_W-1:0]             k_r;
  logic signed [TENTHS_W-1:0] tenths_r;
  // result registers
  logic [RAW_W-1:0]           out_raw_r;
  logic signed [V_W-1:0]      out_v_r;
  logic signed [31:0]         out_pwr_r;
  logic                       out_below_r;
  logic signed [TENTHS_W-1:0] out_tenths_r;
  logic [BAR_W-1:0]           out_bar_r;

  logic [CNT_W-1:0]         cnt_eff;
  logic [SUM_W:0]           sum_add;
  logic [SUM_W-1:0]         sum_sat;
  logic signed [21:0]       off_cnt;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] rnd12;
  logic signed [PROD_W-1:0] rnd20;
  logic signed [PROD_W-1:0] acc_rnd;
  logic signed [PROD_W-1:0] log_rnd;
  logic signed [LOG_W-1:0]  log_l;
  logic [31:0]              sq_t;
  logic signed [31:0]       pwr_sat;
  logic signed [TENTHS_W:0] bar_x;
  logic [CNT_W-1:0]         bar_q;

  always_comb begin
    if (cfg.sample_count == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (cfg.sample_count > CNT_W'(MAX_AVERAGE)) begin
      cnt_eff = CNT_W'(MAX_AVERAGE);
    end else begin
      cnt_eff = cfg.sample_count;
    end
  end

  assign sum_add = {1'b0, run_r} + (SUM_W + 1)'(in_sample);
  assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign off_cnt = cfg.offset_adjust * $signed({1'b0, cnt_eff});

  assign log_l = $signed({1'b0, e_r, frac_r}) - LOG_W'(LOG_BIAS);

  always_comb begin
    unique case (op)
      OP_MUL_V: begin
        mul_a = MUL_W'(corr_r);
        mul_b = $signed({1'b0, cfg.cal_factor});
      end
      OP_MUL_V2: begin
        mul_a = MUL_W'(v_r);
        mul_b = MUL_W'(v_r);
      end
      OP_MUL_V3: begin
        mul_a = MUL_W'(v2_r);
        mul_b = MUL_W'(v_r);
      end
      OP_MUL_C1: begin
        mul_a = MUL_W'(cfg.coef_linear);
        mul_b = MUL_W'(v_r);
      end
      OP_MUL_C2: begin
        mul_a = MUL_W'(cfg.coef_square);
        mul_b = MUL_W'(v2_r);
      end
      OP_MUL_C3: begin
        mul_a = MUL_W'(cfg.coef_cube);
        mul_b = MUL_W'(v3_r);
      end
      OP_SQ_MUL: begin
        mul_a = $signed({2'b00, m_r});
        mul_b = $signed({2'b00, m_r});
      end
      OP_LOG_MUL: begin
        mul_a = MUL_W'(log_l);
        mul_b = MUL_W'(LOG_K);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rnd12   = rshr(prod_r, 12);
  assign rnd20   = rshr(prod_r, 20);
  assign acc_rnd = rshr(PROD_W'(acc_r), 20);
  assign log_rnd = rshr(prod_r, 32) + PROD_W'(TENTHS_OFFSET);
  assign sq_t    = prod_r[61:30];

  always_comb begin
    if (acc_rnd > P_MAX) begin
      pwr_sat = P_MAX[31:0];
    end else if (acc_rnd < P_MIN) begin
      pwr_sat = P_MIN[31:0];
    end else begin
      pwr_sat = acc_rnd[31:0];
    end
  end

  // bar = trunc((tenths + 2) / 4), negative values clamp to zero
  assign bar_x = (TENTHS_W + 1)'(tenths_r) + (TENTHS_W + 1)'(2);
  assign bar_q = CNT_W'(bar_x[TENTHS_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= '0;
      seen_r <= '0;
    end else if (op == OP_ACC) begin
      if (status.last) begin
        run_r  <= '0;
        seen_r <= '0;
      end else begin
        run_r  <= sum_sat;
        seen_r <= seen_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (op)
      OP_ACC: begin
        if (status.last) begin
          sum_r <= sum_sat;
        end
      end
      OP_CORR: corr_r <= $signed({2'b00, sum_r}) + CORR_W'(off_cnt);
      OP_RND_V: begin
        if (rnd12 > V_MAX) begin
          v_r <= V_MAX[V_W-1:0];
        end else if (rnd12 < V_MIN) begin
          v_r <= V_MIN[V_W-1:0];
        end else begin
          v_r <= rnd12[V_W-1:0];
        end
      end
      OP_RND_V2: v2_r <= rnd20[V2_W-1:0];
      OP_RND_V3: begin
        v3_r  <= rnd20[V3_W-1:0];
        acc_r <= $signed({{(ACC_W - 52){cfg.coef_const[31]}}, cfg.coef_const, 20'd0});
      end
      OP_ADD: acc_r <= acc_r + prod_r[ACC_W-1:0];
      OP_PWR: begin
        below_r <= pwr_sat < $signed({1'b0, cfg.power_min});
        pwr_r   <= (pwr_sat < $signed({1'b0, cfg.power_min})) ? '0 : pwr_sat;
      end
      OP_NORM_LD: begin
        m_r      <= pwr_r[30:0];
        e_r      <= EXP_W'(30);
        frac_r   <= '0;
        k_r      <= '0;
        tenths_r <= TENTHS_W'(TENTHS_BELOW);
      end
      OP_NORM: begin
        if (!status.norm_done) begin
          m_r <= {m_r[29:0], 1'b0};
          e_r <= e_r - EXP_W'(1);
        end
      end
      OP_SQ_UPD: begin
        k_r <= k_r + K_W'(1);
        if (sq_t[31]) begin
          m_r    <= sq_t[31:1];
          frac_r <= {frac_r[FRAC_W-2:0], 1'b1};
        end else begin
          m_r    <= sq_t[30:0];
          frac_r <= {frac_r[FRAC_W-2:0], 1'b0};
        end
      end
      OP_LOG_RND: begin
        if (log_rnd > T_MAX) begin
          tenths_r <= T_MAX[TENTHS_W-1:0];
        end else if (log_rnd < T_MIN) begin
          tenths_r <= T_MIN[TENTHS_W-1:0];
        end else begin
          tenths_r <= log_rnd[TENTHS_W-1:0];
        end
      end
      OP_LOAD: begin
        out_raw_r    <= sum_r[SUM_W-1] ? {RAW_W{1'b1}} : sum_r[RAW_W-1:0];
        out_v_r      <= v_r;
        out_pwr_r    <= pwr_r;
        out_below_r  <= below_r;
        out_tenths_r <= tenths_r;
        if (bar_x[TENTHS_W]) begin
          out_bar_r <= '0;
        end else if (bar_q > CNT_W'(BAR_MAX)) begin
          out_bar_r <= BAR_W'(BAR_MAX);
        end else begin
          out_bar_r <= bar_q[BAR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign status.last      = ({1'b0, seen_r} + (CNT_W + 1)'(1)) >= {1'b0, cnt_eff};
  assign status.skip_log  = below_r || (pwr_r == '0);
  assign status.norm_done = m_r[30] || (e_r == '0);
  assign status.sq_done   = (k_r == K_W'(FRAC_W - 1));

  assign raw_sum        = out_raw_r;
  assign detector_volts = out_v_r;
  assign power_watts    = out_pwr_r;
  assign below_min      = out_below_r;
  assign dbm_tenths     = out_tenths_r;
  assign bar_width      = out_bar_r;

endmodule

// ----- rtl/rfpdl_ctrl.sv -----
// Controller: sequences accumulation, polynomial, log2 and result hand-off.
module rfpdl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rfpdl_pkg::status_t status,
  output rfpdl_pkg::op_t     op
);
  import rfpdl_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CORR, ST_MUL_V, ST_RND_V, ST_MUL_V2, ST_RND_V2, ST_MUL_V3, ST_RND_V3,
    ST_MUL_C1, ST_ADD1, ST_MUL_C2, ST_ADD2, ST_MUL_C3, ST_ADD3, ST_PWR, ST_NORM_LD,
    ST_NORM, ST_SQ_MUL, ST_SQ_UPD, ST_LOG_MUL, ST_LOG_RND, ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    op            = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op = OP_ACC;
          if (status.last) begin
            state_nxt = ST_CORR;
          end
        end
      end
      ST_CORR:   begin op = OP_CORR;   state_nxt = ST_MUL_V;  end
      ST_MUL_V:  begin op = OP_MUL_V;  state_nxt = ST_RND_V;  end
      ST_RND_V:  begin op = OP_RND_V;  state_nxt = ST_MUL_V2; end
      ST_MUL_V2: begin op = OP_MUL_V2; state_nxt = ST_RND_V2; end
      ST_RND_V2: begin op = OP_RND_V2; state_nxt = ST_MUL_V3; end
      ST_MUL_V3: begin op = OP_MUL_V3; state_nxt = ST_RND_V3; end
      ST_RND_V3: begin op = OP_RND_V3; state_nxt = ST_MUL_C1; end
      ST_MUL_C1: begin op = OP_MUL_C1; state_nxt = ST_ADD1;   end
      ST_ADD1:   begin op = OP_ADD;    state_nxt = ST_MUL_C2; end
      ST_MUL_C2: begin op = OP_MUL_C2; state_nxt = ST_ADD2;   end
      ST_ADD2:   begin op = OP_ADD;    state_nxt = ST_MUL_C3; end
      ST_MUL_C3: begin op = OP_MUL_C3; state_nxt = ST_ADD3;   end
      ST_ADD3:   begin op = OP_ADD;    state_nxt = ST_PWR;    end
      ST_PWR:    begin op = OP_PWR;    state_nxt = ST_NORM_LD; end
      ST_NORM_LD: begin
        op        = OP_NORM_LD;
        state_nxt = status.skip_log ? ST_DONE : ST_NORM;
      end
      ST_NORM: begin
        op = OP_NORM;
        if (status.norm_done) begin
          state_nxt = ST_SQ_MUL;
        end
      end
      ST_SQ_MUL: begin op = OP_SQ_MUL; state_nxt = ST_SQ_UPD; end
      ST_SQ_UPD: begin
        op        = OP_SQ_UPD;
        state_nxt = status.sq_done ? ST_LOG_MUL : ST_SQ_MUL;
      end
      ST_LOG_MUL: begin op = OP_LOG_MUL; state_nxt = ST_LOG_RND; end
      ST_LOG_RND: begin op = OP_LOG_RND; state_nxt = ST_DONE;    end
      ST_DONE: begin
        if (slot_free) begin
          op            = OP_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/rf_power_detector_linearizer_top.sv -----
// RF power detector linearizer: sample averaging, cubic linearization and dBm readout.
// Each accepted item is one detector ADC sample; samples are summed until the
// configured count is reached, and the last sample of a group produces one
// result item: the raw sum, the corrected detector voltage, the polynomial
// power, a below-minimum flag, tenths of dBm and a bar width. After a sample
// that does not end a group the block is ready for the next sample. The last
// sample of a group starts a measurement on one shared 33x33 multiplier: the
// voltage and polynomial, one-bit normalization ahead of the log2, repeated
// squaring for 16 log2 fraction bits, then scaling to dBm and registering
// the result; the log2 steps are skipped when power is below the minimum or
// zero. No new sample is taken during a measurement; a finished result waits
// in the output register and samples keep being accepted while it waits.
// Configuration is an APB-style register file at byte address 4*index, always
// ready; the user must write it only while idle, which the block does not enforce.

module rf_power_detector_linearizer_top #(
  parameter int SAMPLE_BITS = rfpdl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [SAMPLE_BITS-1:0]               in_adc_sample,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rfpdl_pkg::RAW_W-1:0]          out_raw_sum,
  output logic signed [rfpdl_pkg::V_W-1:0]     out_detector_volts,
  output logic signed [31:0]                   out_power_watts,
  output logic                                 out_below_min,
  output logic signed [rfpdl_pkg::TENTHS_W-1:0] out_dbm_tenths,
  output logic [rfpdl_pkg::BAR_W-1:0]          out_bar_width,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rfpdl_pkg::ADDR_W-1:0]         paddr,
  input  logic [rfpdl_pkg::DATA_W-1:0]         pwdata,
  output logic [rfpdl_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready
);
  import rfpdl_pkg::*;

  cfg_t    cfg;
  status_t status;
  op_t     op;

  // register file
  rfpdl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: one op per cycle to the datapath
  rfpdl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .op        (op)
  );

  // accumulator, shared multiplier and result register
  rfpdl_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .cfg            (cfg),
    .in_sample      (in_adc_sample),
    .status         (status),
    .raw_sum        (out_raw_sum),
    .detector_volts (out_detector_volts),
    .power_watts    (out_power_watts),
    .below_min      (out_below_min),
    .dbm_tenths     (out_dbm_tenths),
    .bar_width      (out_bar_width)
  );

endmodule

// ----- rtl/rfpdl_checker.sv -----
// Port-level checker of the power detector linearizer, bound to the top level.
`include "rf_power_detector_linearizer_top_macros.svh"

module rfpdl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [19:0]        out_raw_sum,
  input logic signed [31:0] out_power_watts,
  input logic               out_below_min,
  input logic signed [10:0] out_dbm_tenths,
  input logic [7:0]         out_bar_width
);

  `RFPDL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_raw_sum), "result item dropped or changed while stalled")

  `RFPDL_ASSERT_NOW(a_below_fields, out_valid && out_below_min, out_power_watts == 32'sd0 && out_dbm_tenths == -11'sd990 && out_bar_width == 8'd0, "below-minimum result not zeroed")

  `RFPDL_ASSERT_NOW(a_ranges, out_valid, out_bar_width <= 8'd128 && out_dbm_tenths >= -11'sd990 && out_dbm_tenths <= 11'sd600, "dBm or bar out of range")

  `RFPDL_ASSERT_NOW(a_floor_bar, out_valid && out_dbm_tenths == -11'sd990, out_bar_width == 8'd0, "bar not empty at the dBm floor")

endmodule

bind rf_power_detector_linearizer_top rfpdl_checker u_rfpdl_checker (.*);

// ----- tb/rf_power_detector_linearizer_top_test.sv -----
// Self-checking testbench of the RF power detector linearizer top level.
`timescale 1ns / 1ps

module rf_power_detector_linearizer_top_test;
  import rfpdl_pkg::*;

  localparam int  SBITS     = 12;
  localparam int  SUM_CAP   = (1 << 21) - 1;
  localparam int  DRAIN_CYC = 120;
  localparam int  CYC_LIMIT = 2_000_000;
  localparam int  N_ITEMS   = 1850;

  // One expected measurement result.
  typedef struct packed {
    logic [RAW_W-1:0]    raw;
    logic [V_W-1:0]      volts;
    logic [31:0]         watts;
    logic                below;
    logic [TENTHS_W-1:0] tenths;
    logic [BAR_W-1:0]    bar;
  } meas_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SBITS-1:0] in_adc_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [RAW_W-1:0] out_raw_sum;
  logic signed [V_W-1:0] out_detector_volts;
  logic signed [31:0] out_power_watts;
  logic out_below_min;
  logic signed [TENTHS_W-1:0] out_dbm_tenths;
  logic [BAR_W-1:0] out_bar_width;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  rf_power_detector_linearizer_top #(.SAMPLE_BITS(SBITS)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the register file and the group accumulator.
  logic [8:0]  sh_count;
  logic [11:0] sh_offset;
  logic [31:0] sh_cal, sh_c0, sh_c1, sh_c2, sh_c3;
  logic [30:0] sh_pmin;
  int unsigned grp_sum, grp_seen;

  meas_t meas_expected[$];
  logic [SBITS-1:0] sample_queue[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  no_gaps = 1'b0;   // per phase: back-to-back traffic on both sides

  // Shift right with round half away from zero.
  function automatic longint round_shift(longint v, int n);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) << (n - 1))) >>> n;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // log2 in Q5.16 by repeated squaring of the normalized mantissa.
  function automatic longint log2_fixed(logic [31:0] p);
    int e = 30;
    longint unsigned m;
    longint frac = 0;
    while (e > 0 && p[e] == 1'b0) e--;
    m = longint'(p) << (30 - e);
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(e) << 16) | frac;
  endfunction

  // Adds one sample to the group; on the last sample queues the measurement.
  function automatic void accumulate_sample(logic [SBITS-1:0] s);
    int unsigned cnt;
    longint corr, v, v2, v3, acc, pwr, l;
    longint tenths = TENTHS_BELOW;
    longint bar = 0;
    bit below;
    meas_t r;
    cnt = (sh_count == 0) ? 1 : sh_count;
    if (cnt > MAX_AVERAGE) cnt = MAX_AVERAGE;
    grp_sum += s;
    if (grp_sum > SUM_CAP) grp_sum = SUM_CAP;
    grp_seen++;
    if (grp_seen < cnt) return;
    corr = longint'(grp_sum) + longint'($signed(sh_offset)) * longint'(cnt);
    v = clamp(round_shift(corr * longint'(sh_cal), 12), -2097152, 2097151);
    v2 = round_shift(v * v, 20);
    v3 = round_shift(v2 * v, 20);
    acc = longint'($signed(sh_c0)) * (longint'(1) << 20) + longint'($signed(sh_c1)) * v
        + longint'($signed(sh_c2)) * v2 + longint'($signed(sh_c3)) * v3;
    pwr = clamp(round_shift(acc, 20), -64'sd2147483648, 64'sd2147483647);
    below = pwr < longint'(sh_pmin);
    if (below) begin
      pwr = 0;
    end else if (pwr > 0) begin
      l = log2_fixed(pwr[31:0]) - (longint'(24) << 16);
      tenths = clamp(round_shift(l * LOG_K, 32) + TENTHS_OFFSET, TENTHS_BELOW, TENTHS_MAX);
      bar = clamp((tenths + 2) / 4, 0, BAR_MAX);
    end
    r.raw    = (grp_sum > 32'hFFFFF) ? 20'hFFFFF : grp_sum[19:0];
    r.volts  = v[V_W-1:0];
    r.watts  = pwr[31:0];
    r.below  = below;
    r.tenths = tenths[TENTHS_W-1:0];
    r.bar    = bar[BAR_W-1:0];
    meas_expected.push_back(r);
    grp_sum = 0;
    grp_seen = 0;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Track register writes as the block sees them.
  always @(posedge clk) begin
    if (!rst_n) begin
      sh_count  <= 9'd4;
      sh_offset <= 12'd0;
      sh_cal    <= 32'd67109;
      sh_c0     <= -32'sd670;
      sh_c1     <= 32'sd4060326;
      sh_c2     <= 32'sd568757568;
      sh_c3     <= 32'd0;
      sh_pmin   <= 31'd16777;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_SAMPLE_COUNT:  sh_count  <= pwdata[8:0];
        REG_OFFSET_ADJUST: sh_offset <= pwdata[11:0];
        REG_CAL_FACTOR:    sh_cal    <= pwdata;
        REG_COEF_CONST:    sh_c0     <= pwdata;
        REG_COEF_LINEAR:   sh_c1     <= pwdata;
        REG_COEF_SQUARE:   sh_c2     <= pwdata;
        REG_COEF_CUBE:     sh_c3     <= pwdata;
        REG_POWER_MIN:     sh_pmin   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Sample driver: predicts on acceptance, then idles or presents the next item.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      grp_sum = 0;
      grp_seen = 0;
    end else begin
      if (in_valid && in_ready) accumulate_sample(in_adc_sample);
      if (in_valid && !in_ready) begin
        // hold the item until taken
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (sample_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_adc_sample <= sample_queue.pop_front();
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure.
  int out_stall = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (meas_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item, raw_sum %0d", out_raw_sum);
        end else begin
          meas_t e;
          e = meas_expected.pop_front();
          if (e !== {out_raw_sum, out_detector_volts, out_power_watts, out_below_min,
                     out_dbm_tenths, out_bar_width}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp raw %0d v %0d p %0d below %0d dbm %0d bar %0d / got raw %0d v %0d p %0d below %0d dbm %0d bar %0d",
                       e.raw, $signed(e.volts), $signed(e.watts), e.below, $signed(e.tenths),
                       e.bar, out_raw_sum, out_detector_volts, out_power_watts, out_below_min,
                       out_dbm_tenths, out_bar_width);
          end
        end
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) out_stall <= pick_gap();
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("rf_power_detector_linearizer_top_test failed");
      $finish;
    end
  end

  task automatic cfg_write(reg_idx_t r, logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_all(logic [31:0] cnt, logic [31:0] off, logic [31:0] cal,
                         logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                         logic [31:0] c3, logic [31:0] pmin);
    cfg_write(REG_SAMPLE_COUNT, cnt);
    cfg_write(REG_OFFSET_ADJUST, off);
    cfg_write(REG_CAL_FACTOR, cal);
    cfg_write(REG_COEF_CONST, c0);
    cfg_write(REG_COEF_LINEAR, c1);
    cfg_write(REG_COEF_SQUARE, c2);
    cfg_write(REG_COEF_CUBE, c3);
    cfg_write(REG_POWER_MIN, pmin);
  endtask

  // Sender holds off until every queued item is taken and every result is back.
  // The check repeats after the quiet period so an item presented at the edge
  // of the first check is still seen through.
  task automatic drain();
    do begin
      while (sample_queue.size() > 0 || in_valid || meas_expected.size() > 0) @(posedge clk);
      repeat (DRAIN_CYC) @(posedge clk);
    end while (sample_queue.size() > 0 || in_valid || meas_expected.size() > 0);
  endtask

  task automatic push_random(int n, inout int total);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      sample_queue.push_back(r == 0 ? 12'd0 : (r == 1 ? 12'hFFF : 12'($urandom_range(0, 4095))));
    end
    total += n;
  endtask

  initial begin
    int total;
    int mode;
    logic [31:0] cnt;
    total = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, sample extremes.
    for (int i = 0; i < 4; i++) sample_queue.push_back(12'd0);
    for (int i = 0; i < 4; i++) sample_queue.push_back(12'hFFF);
    for (int i = 0; i < 8; i++) sample_queue.push_back(12'd1 << (i + 4));
    total += 16;
    drain();
    // Count of one, offset extremes with full-scale gain: voltage saturates both ways.
    cfg_all(1, 32'hFFFF_F800, 32'hFFFF_FFFF, $urandom, $urandom, $urandom, $urandom, 1);
    sample_queue.push_back(12'd0);
    sample_queue.push_back(12'hFFF);
    total += 2;
    drain();
    cfg_all(0, 32'd2047, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF);
    sample_queue.push_back(12'hFFF);
    sample_queue.push_back(12'd0);
    total += 2;
    drain();
    // Zero gain, zero power with a zero minimum.
    cfg_all(2, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    for (int i = 0; i < 4; i++) sample_queue.push_back(12'($urandom_range(0, 4095)));
    total += 4;
    drain();
    // Count above the maximum acts as the maximum: one full-scale group.
    cfg_all(300, 0, 67109, -670, 4060326, 568757568, 0, 16777);
    for (int i = 0; i < 256; i++) sample_queue.push_back(12'hFFF);
    total += 256;
    drain();
    // Lowering the count mid-group ends the group on the next sample.
    cfg_write(REG_SAMPLE_COUNT, 8);
    push_random(5, total);
    drain();
    cfg_write(REG_SAMPLE_COUNT, 2);
    push_random(4, total);
    drain();

    // Random phases.
    while (total < N_ITEMS) begin
      mode = $urandom_range(0, 3);
      cnt = $urandom_range(0, 9) == 0 ? $urandom_range(0, 511) : $urandom_range(1, 8);
      if (cnt > 40) cnt = $urandom_range(0, 3) == 0 ? cnt : $urandom_range(9, 40);
      case (mode)
        0: cfg_all(cnt, 0, 67109, -670, 4060326, 568757568, 0, 16777);
        1: cfg_all(cnt, $urandom_range(0, 4095), 67109 + $urandom_range(0, 200000),
                   -670 + $urandom_range(0, 2000), 4060326 + $urandom_range(0, 4000000),
                   568757568 - $urandom_range(0, 300000000), $urandom_range(0, 50000000),
                   $urandom_range(1, 200000));
        2: cfg_all(cnt, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: cfg_all(cnt, $urandom_range(0, 1) ? 32'd2047 : 32'hFFFF_F800,
                         $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(0, 300000),
                         $urandom, $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                         $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000, $urandom,
                         $urandom_range(0, 1) ? 1 : 32'h7FFF_FFFF);
      endcase
      no_gaps = ($urandom_range(0, 4) == 0);
      push_random((cnt > 40) ? 2 * ((cnt > 256) ? 256 : cnt) + 1 : $urandom_range(20, 80), total);
      drain();
    end

    if (mismatches == 0 && meas_expected.size() == 0)
      $display("rf_power_detector_linearizer_top_test passed");
    else
      $display("rf_power_detector_linearizer_top_test failed");
    $finish;
  end

endmodule
